@@ hdl/rlc_pkg.sv @@
`timescale 1ns / 1ps

package rlc_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int PCT_W     = 7;
    localparam int PCT_SCALE = 100;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        LEVEL_NONE     = 2'd0,
        LEVEL_LIGHT    = 2'd1,
        LEVEL_MODERATE = 2'd2,
        LEVEL_HEAVY    = 2'd3
    } rain_level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT    = 2'd0,
        CFG_MODERATE = 2'd1,
        CFG_HEAVY    = 2'd2,
        CFG_FALLS    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] light_level;
        logic [SAMPLE_W-1:0] moderate_level;
        logic [SAMPLE_W-1:0] heavy_level;
        logic                falls_with_rain;
    } rlc_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered_value;
        logic [SAMPLE_W-1:0] raw_value;
    } rlc_filt_t;

    // Packed so that raw_value lands in the lowest bits of the output word.
    typedef struct packed {
        logic                raining;
        logic                level_changed;
        rain_level_t         rain_level;
        logic [PCT_W-1:0]    percent;
        logic [SAMPLE_W-1:0] filtered_value;
        logic [SAMPLE_W-1:0] raw_value;
    } rlc_result_t;

endpackage

@@ hdl/rlc_filter.sv @@
`timescale 1ns / 1ps

module rlc_filter
    import rlc_pkg::*;
#(
    parameter int FILTER_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                accept,
    input  logic [SAMPLE_W-1:0] sample,
    output rlc_filt_t           filt
);

    localparam int DEPTH_LOG = $clog2(FILTER_DEPTH);
    localparam int SUM_W     = SAMPLE_W + DEPTH_LOG;
    localparam int CNT_W     = $clog2(FILTER_DEPTH + 1);
    // floor(x / FILTER_DEPTH) == (x * DIV_MULT) >> DIV_SHIFT for every x below 2**SUM_W.
    localparam int DIV_SHIFT = SUM_W + DEPTH_LOG;
    localparam int MULT_W    = SUM_W + 2;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam logic [63:0] DIV_MULT_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH);
    localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT_FULL[MULT_W-1:0];

    logic [SAMPLE_W-1:0] ring_reg [FILTER_DEPTH];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic                full_reg;
    logic [SAMPLE_W-1:0] raw_reg;
    logic [PROD_W-1:0]   mean_prod;
    rlc_filt_t           filt_reg;
    rlc_filt_t           filt_next;

    // The ring is a shift line: the last tap is the sample that the new one overwrites.
    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(ring_reg[FILTER_DEPTH-1]) + SUM_W'(sample);
        fill_next = (fill_reg < CNT_W'(FILTER_DEPTH)) ? fill_reg + CNT_W'(1) : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg  <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (accept)
        begin
            ring_reg[0] <= sample;
            for (int i = 1; i < FILTER_DEPTH; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            full_reg <= (fill_next == CNT_W'(FILTER_DEPTH));
        end
    end

    // sum_reg doubles as the sum stage payload; it only moves on accept.
    always_comb
    begin
        mean_prod = PROD_W'(sum_reg) * PROD_W'(DIV_MULT);
        filt_next.raw_value      = raw_reg;
        filt_next.filtered_value = full_reg ? mean_prod[DIV_SHIFT +: SAMPLE_W] : raw_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            raw_reg  <= sample;
            filt_reg <= filt_next;
        end
    end

    assign filt = filt_reg;

endmodule

@@ hdl/rlc_grade.sv @@
`timescale 1ns / 1ps

module rlc_grade
    import rlc_pkg::*;
#(
    parameter int FULL_SCALE = 4095
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        valid,
    input  rlc_filt_t   filt,
    input  rlc_cfg_t    cfg,
    output rlc_result_t result
);

    localparam int SCALED_W  = SAMPLE_W + PCT_W;
    localparam int FS_LOG    = $clog2(FULL_SCALE);
    // floor(x / FULL_SCALE) == (x * PCT_MULT) >> PCT_SHIFT for every x below 2**SCALED_W.
    localparam int PCT_SHIFT = SCALED_W + FS_LOG;
    localparam int MULT_W    = SCALED_W + 2;
    localparam int PROD_W    = SCALED_W + MULT_W;
    localparam logic [63:0] PCT_MULT_FULL =
        ((64'd1 << PCT_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    localparam logic [MULT_W-1:0] PCT_MULT = PCT_MULT_FULL[MULT_W-1:0];

    rain_level_t         level_next;
    rain_level_t         current_level_reg;
    rain_level_t         level_reg;
    logic                changed_reg;
    logic [SAMPLE_W-1:0] raw_reg;
    logic [SAMPLE_W-1:0] filtered_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [PROD_W-1:0]   pct_prod;
    logic [SCALED_W-1:0] pct_quot;
    rlc_result_t         result_reg;
    rlc_result_t         result_next;

    // Heavy is tested first, so misordered thresholds let the first match win.
    always_comb
    begin
        if (cfg.falls_with_rain)
        begin
            if (filt.filtered_value <= cfg.heavy_level)
                level_next = LEVEL_HEAVY;
            else if (filt.filtered_value <= cfg.moderate_level)
                level_next = LEVEL_MODERATE;
            else if (filt.filtered_value <= cfg.light_level)
                level_next = LEVEL_LIGHT;
            else
                level_next = LEVEL_NONE;
        end
        else
        begin
            if (filt.filtered_value >= cfg.heavy_level)
                level_next = LEVEL_HEAVY;
            else if (filt.filtered_value >= cfg.moderate_level)
                level_next = LEVEL_MODERATE;
            else if (filt.filtered_value >= cfg.light_level)
                level_next = LEVEL_LIGHT;
            else
                level_next = LEVEL_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_level_reg <= LEVEL_NONE;
        end
        else if (advance && valid)
        begin
            current_level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            raw_reg      <= filt.raw_value;
            filtered_reg <= filt.filtered_value;
            scaled_reg   <= SCALED_W'(filt.filtered_value) * SCALED_W'(PCT_SCALE);
            level_reg    <= level_next;
            changed_reg  <= (level_next != current_level_reg);
        end
    end

    always_comb
    begin
        pct_prod = PROD_W'(scaled_reg) * PROD_W'(PCT_MULT);
        pct_quot = SCALED_W'(pct_prod >> PCT_SHIFT);
        result_next.raw_value      = raw_reg;
        result_next.filtered_value = filtered_reg;
        // A full scale below the largest sample can push the ratio past 100.
        result_next.percent        = (pct_quot > SCALED_W'(PCT_SCALE)) ?
                                     PCT_W'(PCT_SCALE) : pct_quot[PCT_W-1:0];
        result_next.rain_level     = level_reg;
        result_next.level_changed  = changed_reg;
        result_next.raining        = (level_reg != LEVEL_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ hdl/rain_level_classifier.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         sample[11:0]
// m_axis    out        raw_value[11:0], filtered_value[11:0], percent[6:0],
//                      rain_level[1:0], level_changed, raining
// cfg       in         cfg_index selects light, moderate, heavy, falls_with_rain
//
// One word is taken every cycle unless the sink holds the output word.
// The four stages are the ring sum update, the mean multiply, the threshold compare
// with the x100 scale, and the percent multiply into the output register.
// Reset clears the sample ring, running sum, fill count, last level, valid flags and
// configuration; the data registers are not reset.
// When the output word is held by the sink, the whole pipeline freezes and s_tready
// drops until that word is taken.

module rain_level_classifier
    import rlc_pkg::*;
#(
    parameter int FILTER_DEPTH = 16,
    parameter int FULL_SCALE   = 4095
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // sample[11:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // raw_value, filtered_value, percent,
                                             // rain_level, level_changed, raining
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SAMPLE_W-1:0]   cfg_data
);

    rlc_cfg_t    cfg_reg;
    logic        advance;
    logic        accept;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    rlc_filt_t   filt;
    rlc_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LIGHT:    cfg_reg.light_level     <= cfg_data;
                CFG_MODERATE: cfg_reg.moderate_level  <= cfg_data;
                CFG_HEAVY:    cfg_reg.heavy_level     <= cfg_data;
                CFG_FALLS:    cfg_reg.falls_with_rain <= cfg_data[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign advance  = !v4_reg || m_tready;
    assign accept   = s_tvalid && advance;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    rlc_filter #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .accept  (accept),
        .sample  (s_tdata[SAMPLE_W-1:0]),
        .filt    (filt)
    );

    rlc_grade #(
        .FULL_SCALE (FULL_SCALE)
    ) u_grade (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .valid   (v2_reg),
        .filt    (filt),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = OUT_DATA_W'(result);

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.percent <= PCT_W'(PCT_SCALE)))
        else $error("percent above full scale");

    a_raining_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.raining == (result.rain_level != LEVEL_NONE)))
        else $error("raining flag disagrees with rain level");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output is free");

    a_word_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted word lost in the sum stage");

endmodule
